/* rtl/core/ght_pkg.sv */
// ght_pkg: shared types, constants and command structs for the generational handle table.
// No dependencies.
`timescale 1ns / 1ps
package ght_pkg;
  localparam int SLOTS_DEF  = 64;
  localparam int MAX_EXTENT = 8192;
  localparam logic [31:0] GEN_MAX = 32'hffffffff;
  localparam logic [2:0] ST_DORMANT = 3'd1;
  localparam logic [2:0] ST_CLOSED  = 3'd2;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_SETPOS = 3'd1,
    ACT_SETSZ  = 3'd2,
    ACT_SETST  = 3'd3,
    ACT_FOCUS  = 3'd4,
    ACT_LOOKUP = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] handle;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [2:0]  kind;
    logic [2:0]  new_state;
    logic [7:0]  focus_value;
    logic [63:0] owner;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [47:0] handle_out;
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [13:0] w_out;
    logic [13:0] h_out;
    logic [2:0]  state_out;
    logic [2:0]  kind_out;
    logic [7:0]  focus_out;
    logic [63:0] owner_out;
    logic [15:0] layer_out;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, reset scan index
    logic rd;       // issue memory read at scan index / handle slot
    logic step;     // evaluate read data and advance
    logic finish;   // build result of a create or focus walk
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;     // walk over or single access evaluated
  } sts_t;

  function automatic logic extent_ok(input logic [15:0] v);
    return (v != 16'd0) && (v <= 16'(MAX_EXTENT));
  endfunction
endpackage

/* rtl/core/ght_if.sv */
// ght_if: valid/ready channel carrying one item of a given payload type.
// Payload type is a parameter; no package dependency.
`timescale 1ns / 1ps
interface ght_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ght_ctrl.sv */
// ght_ctrl: sequencer for one item: capture, memory read, evaluate, respond.
// Depends on ght_pkg.
`timescale 1ns / 1ps
module ght_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ght_pkg::sts_t sts,
  output ght_pkg::cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EVAL = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.step = 1'b1;
        state_nxt = sts.done ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_load_rd: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.rd)
    else $error("read must follow load");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid)
    else $error("result must follow finish");
`endif
endmodule

/* rtl/core/ght_dp.sv */
// ght_dp: slot table memories, in-use/generation-written flops, scan index and result register.
// Depends on ght_pkg.
`timescale 1ns / 1ps
module ght_dp #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ght_pkg::cmd_t cmd,
  input  ght_pkg::req_t req_in,
  output ght_pkg::sts_t sts,
  output ght_pkg::rsp_t rsp
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ght_pkg::req_t req_r;
  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] gvld_r;
  logic [31:0] mg [SLOTS];
  logic [2:0]  me [SLOTS];

  logic [31:0] mx [SLOTS];
  logic [31:0] my [SLOTS];
  logic [13:0] mw [SLOTS];
  logic [13:0] mh [SLOTS];
  logic [2:0]  mk [SLOTS];
  logic [63:0] mo [SLOTS];
  logic [7:0]  mf [SLOTS];

  logic [IW-1:0] idx_r;
  logic          found_r;
  logic [IW-1:0] fidx_r;
  logic [31:0]   cgen_r;
  logic [31:0]   rx_r, ry_r;
  logic [13:0]   rw_r, rh_r;
  logic [2:0]    rk_r;
  logic [63:0]   ro_r;
  logic [7:0]    rf_r;
  logic          rd_used_r;
  logic [31:0]   rd_gen_r;
  logic [2:0]    rd_est_r;
  ght_pkg::rsp_t rsp_r, rsp_nxt;

  logic [15:0] hnum;
  logic [31:0] hgen;
  logic        hrange;
  logic [IW-1:0] hidx;
  logic        is_scan;
  logic        last;
  logic        hvalid;
  logic        fok;
  logic [IW-1:0] ridx;
  logic        wr_create, wr_pos, wr_sz, wr_st, wr_foc;
  logic [7:0]  foc_val;

  assign hnum    = req_r.handle[15:0];
  assign hgen    = req_r.handle[47:16];
  assign hrange  = (hnum != 16'd0) && (32'(hnum) <= 32'(SLOTS));
  assign hidx    = IW'(hnum - 16'd1);
  assign is_scan = (req_r.action == ght_pkg::ACT_CREATE) || (req_r.action == ght_pkg::ACT_FOCUS);
  assign last    = (32'(idx_r) == 32'(SLOTS - 1));
  assign ridx    = is_scan ? idx_r : hidx;
  assign hvalid  = hrange && (hgen != 32'd0) && rd_used_r && (rd_gen_r == hgen);
  assign fok     = ght_pkg::extent_ok(req_r.size_w) && ght_pkg::extent_ok(req_r.size_h);

  assign sts.done = !is_scan || last || found_r || wr_create ||
                    ((req_r.action == ght_pkg::ACT_CREATE) && !wr_create &&
                     (!fok || req_r.owner == 64'd0));

  always_comb begin
    wr_create = 1'b0; wr_pos = 1'b0; wr_sz = 1'b0; wr_st = 1'b0; wr_foc = 1'b0;
    foc_val = req_r.focus_value;
    if (cmd.step) begin
      case (req_r.action)
        ght_pkg::ACT_CREATE:
          wr_create = fok && (req_r.owner != 64'd0) && !found_r && !rd_used_r &&
                      (rd_gen_r != ght_pkg::GEN_MAX);
        ght_pkg::ACT_SETPOS: wr_pos = hvalid;
        ght_pkg::ACT_SETSZ:  wr_sz  = hvalid && fok;
        ght_pkg::ACT_SETST:  wr_st  = hvalid;
        ght_pkg::ACT_FOCUS: begin
          if (rd_used_r) begin
            if ({rd_gen_r, 16'(32'(idx_r) + 1)} == req_r.handle) wr_foc = 1'b1;
            else if (req_r.focus_value != 8'd0) begin
              wr_foc = 1'b1;
              foc_val = 8'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      gvld_r <= '0;
    end else begin
      if (wr_create) begin
        used_r[ridx] <= 1'b1;
        gvld_r[ridx] <= 1'b1;
      end
      if (wr_st && (req_r.new_state == ght_pkg::ST_CLOSED)) used_r[ridx] <= 1'b0;
    end
  end

  always_comb begin
    rsp_nxt = rsp_r;
    if (cmd.step && !is_scan) begin
      rsp_nxt = '0;
      rsp_nxt.status = 1'b1;
      case (req_r.action)
        ght_pkg::ACT_SETPOS: rsp_nxt.status = !hvalid;
        ght_pkg::ACT_SETSZ:  rsp_nxt.status = !(hvalid && fok);
        ght_pkg::ACT_SETST:  rsp_nxt.status = !hvalid;
        ght_pkg::ACT_LOOKUP: begin
          if (hvalid) begin
            rsp_nxt.status    = 1'b0;
            rsp_nxt.x_out     = rx_r;
            rsp_nxt.y_out     = ry_r;
            rsp_nxt.w_out     = rw_r;
            rsp_nxt.h_out     = rh_r;
            rsp_nxt.state_out = rd_est_r;
            rsp_nxt.kind_out  = rk_r;
            rsp_nxt.focus_out = rf_r;
            rsp_nxt.owner_out = ro_r;
            rsp_nxt.layer_out = 16'(hidx);
          end
        end
        default: ;
      endcase
    end else if (cmd.finish && is_scan) begin
      rsp_nxt = '0;
      if (req_r.action == ght_pkg::ACT_FOCUS) rsp_nxt.status = 1'b0;
      else if (found_r) begin
        rsp_nxt.status     = 1'b0;
        rsp_nxt.handle_out = {cgen_r, 16'(32'(fidx_r) + 1)};
      end else rsp_nxt.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req_in;
    if (cmd.load) begin
      idx_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.step) begin
      if (wr_create) begin
        found_r <= 1'b1;
        fidx_r  <= ridx;
        cgen_r  <= rd_gen_r + 32'd1;
      end
      if (!last) idx_r <= idx_r + IW'(1);
    end
    if (cmd.rd) begin
      rd_used_r <= used_r[ridx];
      rd_gen_r  <= gvld_r[ridx] ? mg[ridx] : 32'd0;
      rd_est_r  <= me[ridx];
      rx_r <= mx[ridx]; ry_r <= my[ridx];
      rw_r <= mw[ridx]; rh_r <= mh[ridx];
      rk_r <= mk[ridx]; ro_r <= mo[ridx];
      rf_r <= mf[ridx];
    end
    if (wr_create) mg[ridx] <= rd_gen_r + 32'd1;
    if (wr_create || wr_st) me[ridx] <= wr_create ? ght_pkg::ST_DORMANT : req_r.new_state;
    if (wr_create || wr_pos) begin
      mx[ridx] <= req_r.pos_x;
      my[ridx] <= req_r.pos_y;
    end
    if (wr_create || wr_sz) begin
      mw[ridx] <= req_r.size_w[13:0];
      mh[ridx] <= req_r.size_h[13:0];
    end
    if (wr_create) begin
      mk[ridx] <= req_r.kind;
      mo[ridx] <= req_r.owner;
    end
    if (wr_create || wr_foc) mf[ridx] <= wr_create ? 8'd0 : foc_val;
    rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;

`ifndef SYNTH
  a_one_create: assert property (@(posedge clk) disable iff (!rst_n) wr_create |=> found_r)
    else $error("create did not mark found");
  a_excl_wr: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({wr_create, wr_pos, wr_sz, wr_st, wr_foc}))
    else $error("more than one table write");
  a_wr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_create || wr_st) |-> cmd.step)
    else $error("write outside evaluate");
`endif
endmodule

/* rtl/core/generational_handle_table_core.sv */
// generational_handle_table_core: top level joining controller, datapath and channels.
// Depends on ght_pkg, ght_if, ght_ctrl, ght_dp.
`timescale 1ns / 1ps
// One item at a time. Set position, set size, set state and look up go
// from accept to result through capture, memory read, evaluate, finish and
// present. Create walks slots from the lowest up, a read and an evaluate per
// slot through the single table read port, and stops at the first free slot
// whose generation is below the maximum, or after the last slot when full; bad
// create arguments end after the first slot. Set focus always walks all slots.
// No clearing pass: in-use and generation-written bits are flops cleared by
// reset; an unwritten generation reads as zero.
module generational_handle_table_core #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ght_if.sink   in_ch,
  ght_if.source out_ch
);
  ght_pkg::cmd_t cmd;
  ght_pkg::sts_t sts;

  ght_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  ght_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .req_in(in_ch.data), .sts(sts), .rsp(out_ch.data)
  );
endmodule

/* test/testbench.sv */
// testbench: checks generational_handle_table_core against an internal table predictor
// with a directed table followed by random create/modify/close/look up traffic.
// Depends on ght_pkg, ght_if and the core RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int NSLOT = 64;
  localparam int N_RANDOM = 1350;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] ST_STOPPED = 3'd0;
  localparam logic [2:0] ACT_BAD_LO = 3'd6;
  localparam logic [2:0] ACT_BAD_HI = 3'd7;

  typedef struct {
    ght_pkg::req_t req;
    bit   typed;
    ght_pkg::rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ght_if #(ght_pkg::req_t) in_ch (clk);
  ght_if #(ght_pkg::rsp_t) out_ch (clk);

  generational_handle_table_core #(.SLOTS(NSLOT)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit          t_used [NSLOT];
  logic [31:0] t_gen  [NSLOT];
  logic [2:0]  t_st   [NSLOT];
  logic [2:0]  t_kind [NSLOT];
  logic [31:0] t_x    [NSLOT];
  logic [31:0] t_y    [NSLOT];
  logic [13:0] t_w    [NSLOT];
  logic [13:0] t_h    [NSLOT];
  logic [63:0] t_own  [NSLOT];
  logic [7:0]  t_foc  [NSLOT];

  ght_pkg::rsp_t pending_rsp [$];
  logic [47:0] live_handles [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_rx = 1'b0;
  bit feeding = 1'b1;

  function automatic bit extent_good(logic [15:0] v);
    return v != 16'd0 && v <= 16'd8192;
  endfunction

  function automatic int slot_of(logic [47:0] h);
    logic [15:0] num;
    logic [31:0] gen;
    num = h[15:0];
    gen = h[47:16];
    if (num == 16'd0 || num > NSLOT || gen == 32'd0) return -1;
    if (!t_used[num-1] || t_gen[num-1] != gen) return -1;
    return num - 1;
  endfunction

  function automatic ght_pkg::rsp_t table_apply(ght_pkg::req_t r);
    ght_pkg::rsp_t o;
    int s;
    o = '0;
    o.status = 1'b1;
    case (r.action)
      ght_pkg::ACT_CREATE: begin
        if (extent_good(r.size_w) && extent_good(r.size_h) && r.owner != 64'd0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!t_used[i] && t_gen[i] != ght_pkg::GEN_MAX) begin
              t_gen[i] = t_gen[i] + 32'd1;
              t_used[i] = 1'b1;
              t_kind[i] = r.kind;
              t_st[i] = ght_pkg::ST_DORMANT;
              t_x[i] = r.pos_x;
              t_y[i] = r.pos_y;
              t_w[i] = r.size_w[13:0];
              t_h[i] = r.size_h[13:0];
              t_own[i] = r.owner;
              t_foc[i] = 8'd0;
              o.handle_out = {t_gen[i], 16'(i + 1)};
              o.status = 1'b0;
              break;
            end
          end
        end
      end
      ght_pkg::ACT_SETPOS: begin
        s = slot_of(r.handle);
        if (s >= 0) begin
          t_x[s] = r.pos_x;
          t_y[s] = r.pos_y;
          o.status = 1'b0;
        end
      end
      ght_pkg::ACT_SETSZ: begin
        if (extent_good(r.size_w) && extent_good(r.size_h)) begin
          s = slot_of(r.handle);
          if (s >= 0) begin
            t_w[s] = r.size_w[13:0];
            t_h[s] = r.size_h[13:0];
            o.status = 1'b0;
          end
        end
      end
      ght_pkg::ACT_SETST: begin
        s = slot_of(r.handle);
        if (s >= 0) begin
          if (r.new_state == ght_pkg::ST_CLOSED) t_used[s] = 1'b0;
          t_st[s] = r.new_state;
          o.status = 1'b0;
        end
      end
      ght_pkg::ACT_FOCUS: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (t_used[i]) begin
            if ({t_gen[i], 16'(i + 1)} == r.handle) t_foc[i] = r.focus_value;
            else if (r.focus_value != 8'd0) t_foc[i] = 8'd0;
          end
        end
        o.status = 1'b0;
      end
      ght_pkg::ACT_LOOKUP: begin
        s = slot_of(r.handle);
        if (s >= 0) begin
          o.x_out = t_x[s];
          o.y_out = t_y[s];
          o.w_out = t_w[s];
          o.h_out = t_h[s];
          o.state_out = t_st[s];
          o.kind_out = t_kind[s];
          o.focus_out = t_foc[s];
          o.owner_out = t_own[s];
          o.layer_out = 16'(s);
          o.status = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic ght_pkg::req_t make_req(logic [2:0] act, logic [47:0] h);
    ght_pkg::req_t r;
    r.action = act;
    r.handle = h;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.size_w = 16'($urandom_range(1, 8192));
    r.size_h = 16'($urandom_range(1, 8192));
    r.kind = 3'($urandom);
    r.new_state = 3'($urandom);
    r.focus_value = 8'($urandom);
    r.owner = {$urandom, $urandom} | 64'd1;
    return r;
  endfunction

  function automatic logic [47:0] pick_handle();
    logic [47:0] h;
    int k;
    if (live_handles.size() == 0 || $urandom_range(0, 99) < 12) begin
      h = 48'({$urandom, $urandom});
      if ($urandom_range(0, 1)) h[15:0] = 16'($urandom_range(0, 65));
      return h;
    end
    k = $urandom_range(0, live_handles.size() - 1);
    h = live_handles[k];
    if ($urandom_range(0, 99) < 5) h[47:16] = h[47:16] + 32'd1;
    return h;
  endfunction

  task automatic send_item(ght_pkg::req_t r, bit typed, ght_pkg::rsp_t want);
    ght_pkg::rsp_t p;
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = table_apply(r);
    if (typed && p != want) begin
      $error("directed row disagrees with predictor: exp %h got %h", want, p);
      errors++;
    end
    pending_rsp.push_back(p);
    if (r.action == ght_pkg::ACT_CREATE && p.status == 1'b0)
      live_handles.push_back(p.handle_out);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %h actual %h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ght_pkg::rsp_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_rsp.size() == 0) begin
        $error("result with no expectation: %h", a);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("status", 64'(e.status), 64'(a.status));
        check_field("handle_out", 64'(e.handle_out), 64'(a.handle_out));
        check_field("x_out", 64'(e.x_out), 64'(a.x_out));
        check_field("y_out", 64'(e.y_out), 64'(a.y_out));
        check_field("w_out", 64'(e.w_out), 64'(a.w_out));
        check_field("h_out", 64'(e.h_out), 64'(a.h_out));
        check_field("state_out", 64'(e.state_out), 64'(a.state_out));
        check_field("kind_out", 64'(e.kind_out), 64'(a.kind_out));
        check_field("focus_out", 64'(e.focus_out), 64'(a.focus_out));
        check_field("owner_out", e.owner_out, a.owner_out);
        check_field("layer_out", 64'(e.layer_out), 64'(a.layer_out));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_rx) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    hold_rx = 1'b0;
    @(posedge clk);
    wait (!rst_n);
    wait (rst_n);
    wait (feeding && pending_rsp.size() == 0 && live_handles.size() > 0);
    repeat (300) @(posedge clk);
    hold_rx = 1'b1;
    repeat (2000) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    row_t rows [$];
    row_t rw;
    ght_pkg::req_t r;
    ght_pkg::rsp_t z;
    int pick;
    logic [47:0] h;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      t_used[i] = 1'b0; t_gen[i] = '0; t_st[i] = ST_STOPPED; t_kind[i] = '0; t_x[i] = '0;
      t_y[i] = '0; t_w[i] = '0; t_h[i] = '0; t_own[i] = '0; t_foc[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    z = '0;
    z.status = 1'b1;
    // lookup of empty table, unknown actions, bad create args: error
    rw.typed = 1'b1;
    rw.want = z;
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0001); rows.push_back(rw);
    rw.req = make_req(ACT_BAD_LO, 48'h0); rows.push_back(rw);
    rw.req = make_req(ACT_BAD_HI, 48'hffff_ffff_ffff); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rw.req.size_w = 16'd0; rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rw.req.size_h = 16'd8193; rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rw.req.size_w = 16'hffff; rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rw.req.owner = 64'd0; rows.push_back(rw);
    // first create: slot 0, generation 1
    rw.want = '0;
    rw.want.handle_out = 48'h0000_0001_0001;
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0);
    rw.req.size_w = 16'd8192; rw.req.size_h = 16'd1;
    rw.req.pos_x = 32'h8000_0000; rw.req.pos_y = 32'h7fff_ffff;
    rw.req.owner = 64'hffff_ffff_ffff_ffff; rw.req.kind = 3'd7;
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rw.req.size_w = 16'd1;
    rw.req.size_h = 16'd8192;
    rw.req.owner = 64'd1; rw.req.kind = 3'd0; rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0001); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'hffff_0000_0001); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_SETPOS, 48'h0000_0001_0002); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_SETSZ, 48'h0000_0001_0002); rw.req.size_w = 16'd0;
    rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_SETSZ, 48'h0000_0001_0002); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_FOCUS, 48'h0000_0001_0001); rw.req.focus_value = 8'hff;
    rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_FOCUS, 48'h0000_0001_0002); rw.req.focus_value = 8'h00;
    rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0001); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_FOCUS, 48'h0); rw.req.focus_value = 8'h5a; rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_SETST, 48'h0000_0001_0002); rw.req.new_state = 3'd7;
    rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0002); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_SETST, 48'h0000_0001_0001);
    rw.req.new_state = ght_pkg::ST_CLOSED;
    rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0001); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_CREATE, 48'd0); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0002_0001); rows.push_back(rw);
    rw.req = make_req(ght_pkg::ACT_LOOKUP, 48'h0000_0001_0041); rows.push_back(rw);

    foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 400 && n < 550);
      pick = $urandom_range(0, 99);
      h = pick_handle();
      if (pick < 22) r = make_req(ght_pkg::ACT_CREATE, h);
      else if (pick < 32) r = make_req(ght_pkg::ACT_SETPOS, h);
      else if (pick < 42) r = make_req(ght_pkg::ACT_SETSZ, h);
      else if (pick < 58) begin
        r = make_req(ght_pkg::ACT_SETST, h);
        if ($urandom_range(0, 1)) r.new_state = ght_pkg::ST_CLOSED;
      end else if (pick < 66) r = make_req(ght_pkg::ACT_FOCUS, h);
      else if (pick < 94) r = make_req(ght_pkg::ACT_LOOKUP, h);
      else r = make_req($urandom_range(0, 1) ? ACT_BAD_HI : ACT_BAD_LO, h);
      if (pick < 42 && $urandom_range(0, 99) < 10) begin
        r.size_w = 16'($urandom);
        r.size_h = 16'($urandom);
        if ($urandom_range(0, 3) == 0) r.owner = 64'd0;
        if ($urandom_range(0, 3) == 0) r.size_h = 16'd0;
      end
      send_item(r, 1'b0, '0);
      if (live_handles.size() > 80) void'(live_handles.pop_front());
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 10) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
